/* rtl/core/nearest_codeword_decoder_unit_macros.svh */
// Assertion macros used by the nearest codeword decoder top level
`ifndef NEAREST_CODEWORD_DECODER_UNIT_MACROS_SVH
`define NEAREST_CODEWORD_DECODER_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define NCD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nearest codeword decoder: same-cycle check failed");

// Check that a condition implies another in the following cycle
`define NCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nearest codeword decoder: next-cycle check failed");

`endif

/* rtl/core/ncd_pkg.sv */
// Package with the types and constants of the nearest codeword decoder
`timescale 1ns / 1ps

package ncd_pkg;

   localparam int MAX_WORDS = 16;
   localparam int MAX_LEN   = 64;

   localparam int CELL_W = $clog2(MAX_WORDS);
   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int NW_W   = CELL_W + 1;

   // Field widths of the items and registers
   localparam int WCOUNT_W = 5;
   localparam int WLEN_W   = 7;
   localparam int IDX_W    = 4;
   localparam int POS_W    = 6;
   localparam int SYM_W    = 8;
   localparam int DIST_W   = 7;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_DATA_W = 7;

   localparam logic [DIST_W-1:0]   COUNT_MAX     = 7'd127;
   localparam logic [WCOUNT_W-1:0] WCOUNT_RESET  = 5'd1;
   localparam logic [WLEN_W-1:0]   WLEN_RESET    = 7'd64;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

   typedef enum logic [0:0] {
      CSR_WORD_COUNT  = 1'b0,
      CSR_WORD_LENGTH = 1'b1
   } csr_index_type;

   // Item travelling down the row of cells, with the running best match
   typedef struct packed {
      logic               valid;
      action_type         action;
      logic [IDX_W-1:0]   word_index;
      logic [POS_W-1:0]   position;
      logic [SYM_W-1:0]   symbol;
      logic               last;
      logic [NW_W-1:0]    n_words;
      logic [IDX_W-1:0]   best_index;
      logic [DIST_W-1:0]  best_distance;
   } tok_type;

endpackage

/* rtl/core/nearest_codeword_decoder_unit.sv */
// Top level of the nearest codeword decoder: block position, cell row, result register
//
// Channels: req_ carries load and decode items (tuser selects which), rsp_ carries
// one result per received block, csr_ writes word_count (index 0) and word_length
// (index 1) and is always ready.
// A load item writes one codebook symbol; a decode item is compared against every
// codeword in use at the current block position. After word_length decode items the
// index of the first codeword with the least mismatch count and that count are sent.
// Throughput: one item per cycle while the row is not stalled. Each item walks a row
// of MAX_WORDS cells, two register stages per cell (store read, then count and
// compare), and the result of the block passes through the result register to rsp_.
// Reset clears counters, block position and pending results; word_count returns to 1
// and word_length to 64. Codebook contents are undefined until loaded.
// While the receiver stalls, items keep flowing; the row holds still only when a
// second result reaches the end of the row while the first one still waits.
`timescale 1ns / 1ps
`include "nearest_codeword_decoder_unit_macros.svh"

module nearest_codeword_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   // req: tdata = word_index[3:0], position[9:4], symbol[17:10], zero fill
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ncd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req: tuser = action (0 load, 1 decode)
   input  logic                               req_tuser,
   // rsp: tdata = best_index[3:0], best_distance[10:4], zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ncd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [0:0]                         csr_index,
   input  logic [ncd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ncd_pkg::*;

   logic [WCOUNT_W-1:0] word_count_ff;
   logic [WLEN_W-1:0]   word_length_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [WLEN_W-1:0]   pos_next;
   logic [WLEN_W-1:0]   len_eff;
   logic [NW_W-1:0]     n_eff;
   logic                blk_end;
   logic                req_accept;
   logic                advance;
   logic                tail_res;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [DIST_W-1:0]   rsp_dist_ff;
   action_type          req_action;
   tok_type             front;
   tok_type             chain [MAX_WORDS+1];

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff  <= WCOUNT_RESET;
         word_length_ff <= WLEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_WORD_COUNT:  word_count_ff  <= csr_data[WCOUNT_W-1:0];
            CSR_WORD_LENGTH: word_length_ff <= csr_data[WLEN_W-1:0];
            default:         word_count_ff  <= word_count_ff;
         endcase
      end
   end

   // Clamp the register values to the supported ranges
   always_comb begin
      if (word_count_ff == '0) begin
         n_eff = NW_W'(1);
      end else if (int'(word_count_ff) > MAX_WORDS) begin
         n_eff = NW_W'(MAX_WORDS);
      end else begin
         n_eff = NW_W'(word_count_ff);
      end
      if (word_length_ff == '0) begin
         len_eff = WLEN_W'(1);
      end else if (int'(word_length_ff) > MAX_LEN) begin
         len_eff = WLEN_W'(MAX_LEN);
      end else begin
         len_eff = word_length_ff;
      end
   end

   // Stall the row only when a result reaches its end with the output still full
   assign tail_res   = chain[MAX_WORDS].valid && (chain[MAX_WORDS].action == ACT_DECODE) &&
                       chain[MAX_WORDS].last;
   assign advance    = !(tail_res && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance;
   assign req_accept = req_tvalid && req_tready;
   assign req_action = action_type'(req_tuser);

   // Track the position inside the received block
   assign pos_next = {1'b0, pos_ff} + 1'b1;
   assign blk_end  = (pos_next >= len_eff);

   always_comb begin
      pos_in = pos_ff;
      if (req_accept && (req_action == ACT_DECODE)) begin
         pos_in = blk_end ? '0 : pos_next[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Build the item that enters the first cell
   always_comb begin
      front.valid         = req_accept;
      front.action        = req_action;
      front.word_index    = req_tdata[3:0];
      front.position      = (req_action == ACT_DECODE) ? pos_ff : req_tdata[9:4];
      front.symbol        = req_tdata[17:10];
      front.last          = (req_action == ACT_DECODE) && blk_end;
      front.n_words       = n_eff;
      front.best_index    = '0;
      front.best_distance = '0;
   end

   assign chain[0] = front;

   // Row of codeword cells
   for (genvar g = 0; g < MAX_WORDS; g++) begin : g_cell
      ncd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_id (CELL_W'(g)),
         .tok_in  (chain[g]),
         .tok_out (chain[g+1])
      );
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && tail_res) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail_res) begin
         rsp_index_ff <= chain[MAX_WORDS].best_index;
         rsp_dist_ff  <= chain[MAX_WORDS].best_distance;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - IDX_W - DIST_W){1'b0}}, rsp_dist_ff, rsp_index_ff};

   // Checks on the block's own logic
   `NCD_ASSERT_IMPL(a_pos_in_range, 1'b1, (int'(pos_ff) < MAX_LEN))
   `NCD_ASSERT_IMPL(a_best_in_use, tail_res,
      ({1'b0, chain[MAX_WORDS].best_index} < (IDX_W+1)'(chain[MAX_WORDS].n_words)))
   `NCD_ASSERT_IMPL(a_dist_bounded, rsp_valid_ff, (int'(rsp_dist_ff) <= MAX_LEN))
   `NCD_ASSERT_NEXT(a_result_loaded, (advance && tail_res), rsp_valid_ff)

endmodule

/* rtl/core/ncd_cell.sv */
// One codeword cell: codeword symbol store, mismatch counter and minimum compare
`timescale 1ns / 1ps

module ncd_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [ncd_pkg::CELL_W-1:0]   cell_id,
   input  ncd_pkg::tok_type             tok_in,
   output ncd_pkg::tok_type             tok_out
);
   import ncd_pkg::*;

   logic [SYM_W-1:0]  mem [MAX_LEN];
   logic [SYM_W-1:0]  rd_ff;
   tok_type           stage_ff;
   tok_type           out_ff;
   tok_type           out_in;
   logic [DIST_W-1:0] count_ff;
   logic [DIST_W-1:0] count_in;
   logic [DIST_W-1:0] count_upd;
   logic              write_en;
   logic              in_use;
   logic              is_decode;
   logic              take_best;

   // Write a codebook symbol addressed to this cell
   assign write_en = tok_in.valid && (tok_in.action == ACT_LOAD) &&
                     (tok_in.word_index == IDX_W'(cell_id)) &&
                     (int'(tok_in.position) < MAX_LEN);

   // Codeword store, one write and one registered read a cycle while the row advances
   always_ff @(posedge clock) begin
      if (advance) begin
         if (write_en) begin
            mem[tok_in.position[ADDR_W-1:0]] <= tok_in.symbol;
         end
         rd_ff <= mem[tok_in.position[ADDR_W-1:0]];
      end
   end

   // Hold the item beside its read data
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= tok_in;
      end
   end

   // Count the mismatch and fold this cell into the running minimum
   always_comb begin
      in_use    = ({1'b0, cell_id} < stage_ff.n_words);
      is_decode = stage_ff.valid && (stage_ff.action == ACT_DECODE);
      count_upd = count_ff;
      if (is_decode && in_use && (rd_ff != stage_ff.symbol) && (count_ff != COUNT_MAX)) begin
         count_upd = count_ff + 1'b1;
      end
      count_in = count_upd;
      if (is_decode && stage_ff.last) begin
         count_in = '0;
      end
      take_best = is_decode && stage_ff.last && in_use &&
                  ((cell_id == '0) || (count_upd < stage_ff.best_distance));
      out_in = stage_ff;
      if (take_best) begin
         out_in.best_index    = IDX_W'(cell_id);
         out_in.best_distance = count_upd;
      end
   end

   // Advance counter and hand the item to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         count_ff <= count_in;
         out_ff   <= out_in;
      end
   end

   assign tok_out = out_ff;

endmodule

/* sim/nearest_codeword_decoder_unit_tb.sv */
// Self-checking testbench for the nearest codeword decoder: directed steps, then random phases
`timescale 1ns / 1ps

module nearest_codeword_decoder_unit_tb;
   import ncd_pkg::*;

   // Wait allowed for the row to empty, with a margin on top
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 300000;

   typedef struct packed {
      logic [IDX_W-1:0]  best_index;
      logic [DIST_W-1:0] best_distance;
   } match_type;

   typedef enum {STEP_CSR, STEP_LOAD, STEP_DECODE} step_kind_type;

   typedef struct {
      step_kind_type   kind;
      csr_index_type   reg_sel;
      logic [IDX_W-1:0] widx;
      logic [POS_W-1:0] pos;
      logic [7:0]      value;
      bit              typed;
      match_type       typed_match;
   } directed_row_type;

   typedef struct {
      logic [6:0] word_count;
      logic [6:0] word_length;
      int         decodes;
      int         send_idle;
      int         recv_idle;
      bit         squeeze;
   } phase_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [0:0]            csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Shadow of the decoder state
   logic [SYM_W-1:0]    codebook_copy [MAX_WORDS][MAX_LEN];
   bit                  written_entry [MAX_WORDS][MAX_LEN];
   logic [DIST_W-1:0]   mismatch_tally [MAX_WORDS];
   int unsigned         block_pos       = 0;
   logic [WCOUNT_W-1:0] cfg_word_count  = WCOUNT_RESET;
   logic [WLEN_W-1:0]   cfg_word_length = WLEN_RESET;

   match_type pending_matches [$];

   int failures       = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 17;
   int recv_idle_pct  = 48;
   int hold_off_asked = 0;
   int hold_off_done  = 0;
   int stall_left     = 0;
   int unsigned target_word = 0;
   int unsigned err_pct     = 0;

   // Directed steps; expected results typed in where they are obvious
   directed_row_type directed_steps [22] = '{
      '{STEP_CSR,    CSR_WORD_COUNT,  4'd0,  6'd0,  8'd2,  1'b0, {4'd0, 7'd0}},
      '{STEP_CSR,    CSR_WORD_LENGTH, 4'd0,  6'd0,  8'd2,  1'b0, {4'd0, 7'd0}},
      '{STEP_LOAD,   CSR_WORD_COUNT,  4'd0,  6'd0,  8'h00, 1'b0, {4'd0, 7'd0}},
      '{STEP_LOAD,   CSR_WORD_COUNT,  4'd0,  6'd1,  8'hFF, 1'b0, {4'd0, 7'd0}},
      '{STEP_LOAD,   CSR_WORD_COUNT,  4'd1,  6'd0,  8'hFF, 1'b0, {4'd0, 7'd0}},
      '{STEP_LOAD,   CSR_WORD_COUNT,  4'd1,  6'd1,  8'h00, 1'b0, {4'd0, 7'd0}},
      // exact match of word 0, then of word 1
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd15, 6'd63, 8'h00, 1'b0, {4'd0, 7'd0}},
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd0,  6'd0,  8'hFF, 1'b1, {4'd0, 7'd0}},
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd5,  6'd42, 8'hFF, 1'b0, {4'd0, 7'd0}},
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd10, 6'd21, 8'h00, 1'b1, {4'd1, 7'd0}},
      // equal distances: lowest index wins
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd0,  6'd0,  8'h55, 1'b0, {4'd0, 7'd0}},
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd0,  6'd0,  8'hAA, 1'b1, {4'd0, 7'd2}},
      '{STEP_LOAD,   CSR_WORD_COUNT,  4'd15, 6'd63, 8'hA5, 1'b0, {4'd0, 7'd0}},
      // load in the middle of a block, used by the next symbol
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd0,  6'd0,  8'hFF, 1'b0, {4'd0, 7'd0}},
      '{STEP_LOAD,   CSR_WORD_COUNT,  4'd1,  6'd1,  8'h3C, 1'b0, {4'd0, 7'd0}},
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd0,  6'd0,  8'h3C, 1'b1, {4'd1, 7'd0}},
      // zero count and zero length act as one
      '{STEP_CSR,    CSR_WORD_COUNT,  4'd0,  6'd0,  8'd0,  1'b0, {4'd0, 7'd0}},
      '{STEP_CSR,    CSR_WORD_LENGTH, 4'd0,  6'd0,  8'd0,  1'b0, {4'd0, 7'd0}},
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd0,  6'd0,  8'h00, 1'b1, {4'd0, 7'd0}},
      '{STEP_DECODE, CSR_WORD_COUNT,  4'd0,  6'd0,  8'h12, 1'b1, {4'd0, 7'd1}},
      // back to two words of length two, for the block that is shortened below
      '{STEP_CSR,    CSR_WORD_COUNT,  4'd0,  6'd0,  8'd2,  1'b0, {4'd0, 7'd0}},
      '{STEP_CSR,    CSR_WORD_LENGTH, 4'd0,  6'd0,  8'd2,  1'b0, {4'd0, 7'd0}}
   };

   phase_type phases [11] = '{
      '{7'd1,  7'd127, 64, 17, 48, 1'b0},
      '{7'd31, 7'd1,   25, 17, 48, 1'b0},
      '{7'd16, 7'd3,   30, 17, 48, 1'b0},
      '{7'd3,  7'd8,   35, 17, 48, 1'b0},
      '{7'd0,  7'd5,   25, 48, 17, 1'b0},
      '{7'd5,  7'd0,   20, 48, 17, 1'b0},
      '{7'd2,  7'd64,  70, 48, 17, 1'b0},
      '{7'd8,  7'd16,  40, 48, 17, 1'b0},
      '{7'd2,  7'd1,   50, 0,  0,  1'b1},
      '{7'd16, 7'd4,   40, 0,  0,  1'b0},
      '{7'd1,  7'd64,  40, 0,  0,  1'b0}
   };

   nearest_codeword_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned live_word_count();
      if (cfg_word_count == 0) return 1;
      if (cfg_word_count > MAX_WORDS) return MAX_WORDS;
      return cfg_word_count;
   endfunction

   function automatic int unsigned live_block_length();
      if (cfg_word_length == 0) return 1;
      if (cfg_word_length > MAX_LEN) return MAX_LEN;
      return cfg_word_length;
   endfunction

   // Advance the shadow state by one item; report the match a finished block yields
   function automatic void nearest_match_step(input action_type act,
         input logic [IDX_W-1:0] widx, input logic [POS_W-1:0] pos,
         input logic [SYM_W-1:0] sym, output bit produced, output match_type res);
      int unsigned n;
      int unsigned len;
      produced = 1'b0;
      res = '0;
      if (act == ACT_LOAD) begin
         codebook_copy[widx][pos] = sym;
         written_entry[widx][pos] = 1'b1;
         return;
      end
      n = live_word_count();
      len = live_block_length();
      if (block_pos < MAX_LEN) begin
         for (int w = 0; w < n; w++)
            if (codebook_copy[w][block_pos] != sym && mismatch_tally[w] < COUNT_MAX)
               mismatch_tally[w]++;
      end
      block_pos++;
      if (block_pos < len) return;
      res.best_distance = mismatch_tally[0];
      for (int w = 1; w < n; w++) begin
         if (mismatch_tally[w] < res.best_distance) begin
            res.best_distance = mismatch_tally[w];
            res.best_index = IDX_W'(w);
         end
      end
      for (int w = 0; w < MAX_WORDS; w++) mismatch_tally[w] = '0;
      block_pos = 0;
      produced = 1'b1;
   endfunction

   // Offer one item, hold it until taken, then queue any match it completes
   task automatic send_item(input action_type act, input logic [IDX_W-1:0] widx,
         input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym,
         input bit typed, input match_type typed_match);
      bit produced;
      match_type res;
      match_type expected;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'd0, sym, pos, widx};
      do @(posedge clock); while (!req_tready);
      nearest_match_step(act, widx, pos, sym, produced, res);
      if (produced) begin
         expected = typed ? typed_match : res;
         pending_matches = {pending_matches, expected};
      end
      @(negedge clock);
   endtask

   // Write a register once the decoder has drained
   task automatic write_register(input csr_index_type sel, input logic [6:0] value);
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (sel == CSR_WORD_COUNT) cfg_word_count = value[WCOUNT_W-1:0];
      else cfg_word_length = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Send one received symbol, loading first any unwritten codebook entry it will be compared with
   task automatic feed_symbol();
      int unsigned n;
      logic [SYM_W-1:0] sym;
      n = live_word_count();
      for (int w = 0; w < n; w++)
         if (!written_entry[w][block_pos])
            send_item(ACT_LOAD, IDX_W'(w), POS_W'(block_pos), SYM_W'($urandom), 1'b0, '0);
      // pick a codeword to aim at and how badly to corrupt it, once per block
      if (block_pos == 0 || target_word >= n) begin
         target_word = $urandom_range(n - 1);
         case ($urandom_range(3))
            0: err_pct = 0;
            1: err_pct = 100;
            default: err_pct = $urandom_range(100);
         endcase
      end
      sym = codebook_copy[target_word][block_pos];
      if ($urandom_range(99) < err_pct)
         sym = ($urandom_range(1) != 0) ? ~sym : SYM_W'($urandom);
      send_item(ACT_DECODE, IDX_W'($urandom), POS_W'($urandom), sym, 1'b0, '0);
   endtask

   // Result receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_off_asked != hold_off_done) begin
         hold_off_done <= hold_off_asked;
         stall_left    <= HOLD_OFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each result item with the oldest expected match
   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            $error("unexpected result: best_index %0d, best_distance %0d",
                   rsp_tdata[3:0], rsp_tdata[10:4]);
            failures++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_tdata[3:0] != want.best_index) begin
               $error("best_index: expected %0d, actual %0d", want.best_index, rsp_tdata[3:0]);
               failures++;
            end
            if (rsp_tdata[10:4] != want.best_distance) begin
               $error("best_distance: expected %0d, actual %0d",
                      want.best_distance, rsp_tdata[10:4]);
               failures++;
            end
         end
      end
   end

   // Stop a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int k;
      for (int w = 0; w < MAX_WORDS; w++) mismatch_tally[w] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed steps
      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_CSR: begin
               write_register(directed_steps[i].reg_sel, directed_steps[i].value[6:0]);
            end
            STEP_LOAD: begin
               send_item(ACT_LOAD, directed_steps[i].widx, directed_steps[i].pos,
                         directed_steps[i].value, 1'b0, '0);
            end
            default: begin
               send_item(ACT_DECODE, directed_steps[i].widx, directed_steps[i].pos,
                         directed_steps[i].value, directed_steps[i].typed,
                         directed_steps[i].typed_match);
            end
         endcase
      end
      // one symbol into a block of two, shorten to one, then the next symbol closes it
      send_item(ACT_DECODE, 4'd9, 6'd36, 8'h00, 1'b0, '0);
      write_register(CSR_WORD_LENGTH, 7'd1);
      send_item(ACT_DECODE, 4'd6, 6'd27, 8'h3C, 1'b1, {4'd0, 7'd1});

      // Random phases, each with its own setting and idling
      foreach (phases[p]) begin
         send_idle_pct = phases[p].send_idle;
         recv_idle_pct = phases[p].recv_idle;
         write_register(CSR_WORD_COUNT, phases[p].word_count);
         write_register(CSR_WORD_LENGTH, phases[p].word_length);
         if (phases[p].squeeze) hold_off_asked++;
         k = 0;
         while (k < phases[p].decodes) begin
            if ($urandom_range(99) < 8) begin
               send_item(ACT_LOAD, IDX_W'($urandom), POS_W'($urandom), SYM_W'($urandom),
                         1'b0, '0);
            end else begin
               feed_symbol();
               k++;
            end
         end
      end

      // Drain and report
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ncd_pkg.sv
rtl/core/ncd_cell.sv
rtl/core/nearest_codeword_decoder_unit.sv
sim/nearest_codeword_decoder_unit_tb.sv
